// ===== rtl/dbpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpl_pkg
// Shared constants, datapath operation codes and status type for the
// de Bruijn position locator.
// ----------------------------------------------------------------------------
package dbpl_pkg;

   localparam int MAX_LEN    = 1024;
   localparam int MAX_ORDER  = 10;
   localparam int LEN_W      = 11;
   localparam int BITS_W     = 10;
   localparam int WLEN_W     = 4;
   localparam int LOC_W      = 10;
   localparam int ORDER_W    = 4;
   localparam int NODE_W     = MAX_ORDER - 1;
   localparam int EDGE_W     = MAX_ORDER;
   localparam int NODES      = 1 << NODE_W;
   localparam int EDGE_SLOTS = (1 << MAX_ORDER) + 1;
   localparam int SLOT_W     = $clog2(EDGE_SLOTS + 1);
   localparam int LADDR_W    = $clog2(MAX_LEN);
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 32;
   localparam logic [CSR_AW-1:0] CSR_SEQ_LENGTH = 2'd0;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_CLR,
      DP_WALK_INIT,
      DP_FETCH,
      DP_DECIDE,
      DP_POP_LOAD,
      DP_FILL_INIT,
      DP_FILL_RD,
      DP_FILL_WR,
      DP_SCAN_INIT,
      DP_SCAN_RD,
      DP_SCAN_SH,
      DP_SCAN_CMP,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      logic bad_len;
      logic trunc;
      logic clr_last;
      logic push;
      logic last_pop;
      logic fill_last;
      logic primed;
      logic match;
      logic more;
   } dp_status_type;

   function automatic logic [ORDER_W-1:0] pick_order(input logic [LEN_W-1:0] n);
      logic [ORDER_W-1:0] k;
      logic               stop;
      k    = ORDER_W'(1);
      stop = 1'b0;
      for (int i = 1; i < MAX_ORDER; i++) begin
         if (!stop) begin
            if (({1'b0, n} + 12'd1) > (12'(i) + (12'd1 << i))) begin
               k = k + ORDER_W'(1);
            end else begin
               stop = 1'b1;
            end
         end
      end
      return k;
   endfunction

endpackage

// ===== rtl/dbpl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpl request and response channels
// Valid/ready channels carrying a window request and a location response.
// ----------------------------------------------------------------------------
interface dbpl_req_if;
   logic                         valid;
   logic                         ready;
   logic [dbpl_pkg::BITS_W-1:0]  window_bits;
   logic [dbpl_pkg::WLEN_W-1:0]  window_length;
   logic [dbpl_pkg::WLEN_W-1:0]  valid_count;

   modport source (output valid, window_bits, window_length, valid_count, input ready);
   modport sink   (input valid, window_bits, window_length, valid_count, output ready);
endinterface

interface dbpl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [dbpl_pkg::LOC_W-1:0]   location;
   logic [dbpl_pkg::ORDER_W-1:0] order;

   modport source (output valid, found, location, order, input ready);
   modport sink   (input valid, found, location, order, output ready);
endinterface

// ===== rtl/dbpl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpl_datapath
// Length and order registers, Euler walk memories, label store, sliding
// window compare and response registers.
// ----------------------------------------------------------------------------
module dbpl_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_wr,
   input  logic [dbpl_pkg::LEN_W-1:0]    cfg_len,
   output logic [dbpl_pkg::LEN_W-1:0]    seq_len,
   input  dbpl_pkg::dp_op_type           op,
   input  logic [dbpl_pkg::BITS_W-1:0]   in_bits,
   input  logic [dbpl_pkg::WLEN_W-1:0]   in_len,
   input  logic [dbpl_pkg::WLEN_W-1:0]   in_valid,
   output dbpl_pkg::dp_status_type       status,
   output logic                          out_found,
   output logic [dbpl_pkg::LOC_W-1:0]    out_location,
   output logic [dbpl_pkg::ORDER_W-1:0]  out_order
);
   import dbpl_pkg::*;

   logic [LEN_W-1:0]   seq_len_ff;
   logic [ORDER_W-1:0] order_ff;
   logic [BITS_W-1:0]  bits_ff;
   logic [WLEN_W-1:0]  len_ff;
   logic [WLEN_W-1:0]  valid_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic [SLOT_W-1:0]  sp_ff;
   logic [SLOT_W-1:0]  cnt_ff;
   logic [EDGE_W-1:0]  top_ff;
   logic [BITS_W-1:0]  curr_ff;
   logic               found_ff;
   logic [LOC_W-1:0]   loc_ff;
   logic               use_ff;
   logic               out_found_ff;
   logic [LOC_W-1:0]   out_loc_ff;
   logic [ORDER_W-1:0] out_order_ff;

   logic [1:0]         vis_mem [NODES];
   logic [EDGE_W-1:0]  stk_mem [EDGE_SLOTS];
   logic               circ_mem [EDGE_SLOTS];
   logic               lab_mem [MAX_LEN];
   logic [1:0]         vis_q;
   logic [EDGE_W-1:0]  stk_q;
   logic               circ_q;
   logic               lab_q;

   logic [NODE_W:0]    node_mask_w;
   logic [NODE_W-1:0]  node;
   logic [BITS_W:0]    kmask_w;
   logic [BITS_W:0]    tmask_w;
   logic [BITS_W-1:0]  target;
   logic               push0;
   logic               push1;
   logic [11:0]        fill_j;
   logic               fill_use;
   logic [SLOT_W-1:0]  fill_addr;
   logic [LEN_W-1:0]   sat_len;
   logic signed [12:0] trunc_pos;
   logic               in_bad;
   logic               in_trunc;

   assign node_mask_w = ((NODE_W+1)'(1) << (order_ff - ORDER_W'(1))) - (NODE_W+1)'(1);
   assign node        = top_ff[NODE_W-1:0] & node_mask_w[NODE_W-1:0];
   assign kmask_w     = ((BITS_W+1)'(1) << order_ff) - (BITS_W+1)'(1);
   assign tmask_w     = ((BITS_W+1)'(1) << len_ff) - (BITS_W+1)'(1);
   assign target      = bits_ff & tmask_w[BITS_W-1:0];
   assign push0       = !vis_q[0] && (sp_ff < SLOT_W'(EDGE_SLOTS));
   assign push1       = !push0 && !vis_q[1] && (sp_ff < SLOT_W'(EDGE_SLOTS));
   assign fill_j      = 12'(idx_ff) + 12'd2 - 12'(order_ff);
   assign fill_use    = ((12'(idx_ff) + 12'd1) >= 12'(order_ff)) && (fill_j < 12'(cnt_ff));
   assign fill_addr   = SLOT_W'(12'(cnt_ff) - 12'd1 - fill_j);
   assign in_bad      = (in_len == '0) || (in_len > WLEN_W'(MAX_ORDER));
   assign in_trunc    = in_valid < in_len;
   assign trunc_pos   = 13'(seq_len_ff) - 13'(in_len - in_valid) - 13'sd1;

   always_comb begin
      sat_len = cfg_len;
      if (cfg_len < LEN_W'(2)) begin
         sat_len = LEN_W'(2);
      end else if (cfg_len > LEN_W'(MAX_LEN)) begin
         sat_len = LEN_W'(MAX_LEN);
      end
   end

   always_comb begin
      status.bad_len   = (len_ff == '0) || (len_ff > WLEN_W'(MAX_ORDER));
      status.trunc     = valid_ff < len_ff;
      status.clr_last  = idx_ff == SLOT_W'(NODES - 1);
      status.push      = push0 || push1;
      status.last_pop  = sp_ff == SLOT_W'(1);
      status.fill_last = idx_ff == SLOT_W'(seq_len_ff - LEN_W'(1));
      status.primed    = idx_ff >= SLOT_W'(order_ff);
      status.match     = curr_ff == target;
      status.more      = idx_ff < SLOT_W'(seq_len_ff);
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= LEN_W'(MAX_LEN);
         order_ff   <= pick_order(LEN_W'(MAX_LEN));
      end else if (cfg_wr) begin
         seq_len_ff <= sat_len;
         order_ff   <= pick_order(sat_len);
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (op == DP_CLR) begin
         vis_mem[idx_ff[NODE_W-1:0]] <= 2'b00;
      end else if (op == DP_DECIDE && push0) begin
         vis_mem[node] <= vis_q | 2'b01;
      end else if (op == DP_DECIDE && push1) begin
         vis_mem[node] <= vis_q | 2'b10;
      end
      vis_q <= vis_mem[node];
   end

   always_ff @(posedge clock) begin
      if (op == DP_DECIDE && (push0 || push1)) begin
         stk_mem[sp_ff - SLOT_W'(1)] <= top_ff;
      end
      stk_q <= stk_mem[sp_ff - SLOT_W'(2)];
   end

   always_ff @(posedge clock) begin
      if (op == DP_DECIDE && !push0 && !push1 && cnt_ff < SLOT_W'(EDGE_SLOTS)) begin
         circ_mem[cnt_ff] <= top_ff[0];
      end
      circ_q <= circ_mem[fill_addr];
   end

   always_ff @(posedge clock) begin
      if (op == DP_FILL_WR) begin
         lab_mem[idx_ff[LADDR_W-1:0]] <= use_ff ? circ_q : 1'b0;
      end
      lab_q <= lab_mem[idx_ff[LADDR_W-1:0]];
   end

   // work registers
   always_ff @(posedge clock) begin
      case (op)
         DP_CAPTURE: begin
            bits_ff  <= in_bits;
            len_ff   <= in_len;
            valid_ff <= in_valid;
            idx_ff   <= '0;
            found_ff <= 1'b0;
            loc_ff   <= '0;
            if (!in_bad && in_trunc && !trunc_pos[12]) begin
               found_ff <= 1'b1;
               loc_ff   <= trunc_pos[LOC_W-1:0];
            end
         end
         DP_CLR: begin
            idx_ff <= idx_ff + SLOT_W'(1);
         end
         DP_WALK_INIT: begin
            sp_ff  <= SLOT_W'(1);
            top_ff <= '0;
            cnt_ff <= '0;
         end
         DP_DECIDE: begin
            if (push0) begin
               top_ff <= {node, 1'b0};
               sp_ff  <= sp_ff + SLOT_W'(1);
            end else if (push1) begin
               top_ff <= {node, 1'b1};
               sp_ff  <= sp_ff + SLOT_W'(1);
            end else begin
               if (cnt_ff < SLOT_W'(EDGE_SLOTS)) begin
                  cnt_ff <= cnt_ff + SLOT_W'(1);
               end
               sp_ff <= sp_ff - SLOT_W'(1);
            end
         end
         DP_POP_LOAD: begin
            top_ff <= stk_q;
         end
         DP_FILL_INIT: begin
            idx_ff <= '0;
         end
         DP_FILL_RD: begin
            use_ff <= fill_use;
         end
         DP_FILL_WR: begin
            idx_ff <= idx_ff + SLOT_W'(1);
         end
         DP_SCAN_INIT: begin
            idx_ff  <= '0;
            curr_ff <= '0;
         end
         DP_SCAN_SH: begin
            curr_ff <= {curr_ff[BITS_W-2:0], lab_q} & kmask_w[BITS_W-1:0];
            idx_ff  <= idx_ff + SLOT_W'(1);
         end
         DP_SCAN_CMP: begin
            if (idx_ff >= SLOT_W'(order_ff) && curr_ff == target) begin
               found_ff <= 1'b1;
               loc_ff   <= LOC_W'(idx_ff - SLOT_W'(order_ff));
            end
         end
         default: begin
         end
      endcase
   end

   // response registers
   always_ff @(posedge clock) begin
      if (op == DP_OUT) begin
         out_found_ff <= found_ff;
         out_loc_ff   <= loc_ff;
         out_order_ff <= order_ff;
      end
   end

   assign seq_len      = seq_len_ff;
   assign out_found    = out_found_ff;
   assign out_location = out_loc_ff;
   assign out_order    = out_order_ff;

endmodule

// ===== rtl/dbpl_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpl_controller
// Sequences request capture, the label build and the window scan, and
// holds the built flag and the response valid.
// ----------------------------------------------------------------------------
module dbpl_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cfg_wr,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  dbpl_pkg::dp_status_type  status,
   output dbpl_pkg::dp_op_type      op
);
   import dbpl_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CLR,
      ST_WINIT,
      ST_FETCH,
      ST_DECIDE,
      ST_POPLD,
      ST_FINIT,
      ST_FRD,
      ST_FWR,
      ST_SINIT,
      ST_SRD,
      ST_SSH,
      ST_SCMP,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      built_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE:   op = req_valid ? DP_CAPTURE : DP_NOP;
         ST_CLR:    op = DP_CLR;
         ST_WINIT:  op = DP_WALK_INIT;
         ST_FETCH:  op = DP_FETCH;
         ST_DECIDE: op = DP_DECIDE;
         ST_POPLD:  op = DP_POP_LOAD;
         ST_FINIT:  op = DP_FILL_INIT;
         ST_FRD:    op = DP_FILL_RD;
         ST_FWR:    op = DP_FILL_WR;
         ST_SINIT:  op = DP_SCAN_INIT;
         ST_SRD:    op = DP_SCAN_RD;
         ST_SSH:    op = DP_SCAN_SH;
         ST_SCMP:   op = DP_SCAN_CMP;
         ST_DONE:   op = out_free ? DP_OUT : DP_NOP;
         default:   op = DP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg_wr) begin
            built_ff <= 1'b0;
         end else if (state_ff == ST_FWR && status.fill_last) begin
            built_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (status.bad_len || status.trunc) begin
                  state_ff <= ST_DONE;
               end else if (built_ff) begin
                  state_ff <= ST_SINIT;
               end else begin
                  state_ff <= ST_CLR;
               end
            end
            ST_CLR: begin
               if (status.clr_last) begin
                  state_ff <= ST_WINIT;
               end
            end
            ST_WINIT:  state_ff <= ST_FETCH;
            ST_FETCH:  state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               if (status.push) begin
                  state_ff <= ST_FETCH;
               end else if (status.last_pop) begin
                  state_ff <= ST_FINIT;
               end else begin
                  state_ff <= ST_POPLD;
               end
            end
            ST_POPLD:  state_ff <= ST_FETCH;
            ST_FINIT:  state_ff <= ST_FRD;
            ST_FRD:    state_ff <= ST_FWR;
            ST_FWR: begin
               if (status.fill_last) begin
                  state_ff <= ST_SINIT;
               end else begin
                  state_ff <= ST_FRD;
               end
            end
            ST_SINIT:  state_ff <= ST_SCMP;
            ST_SRD:    state_ff <= ST_SSH;
            ST_SSH:    state_ff <= ST_SCMP;
            ST_SCMP: begin
               if (!status.primed) begin
                  state_ff <= ST_SRD;
               end else if (status.match) begin
                  state_ff <= ST_DONE;
               end else if (status.more) begin
                  state_ff <= ST_SRD;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/de_bruijn_position_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// de_bruijn_position_locator
// Finds the start of a window of labels in a binary de Bruijn label
// sequence of configurable length, building the labels on demand.
// ----------------------------------------------------------------------------
//  channel    direction  handshake        contents
//  req_chan   in         valid / ready    window_bits, window_length, valid_count
//  rsp_chan   out        valid / ready    found, location, order
//  csr_*      in         apb write/read   seq_length at byte address 0
//
//  a bad or truncated window goes from the check straight to output handoff
//  a full window scan reads one label at a time over the single label port
//  the first full window after a length write first builds: it clears
//  the visited map, walks the 2^k-edge Euler circuit, then fills the labels
//  one request in flight; the next is taken while a response waits
//  synchronous active-high reset; length resets to 1024, order to 10
// ----------------------------------------------------------------------------
module de_bruijn_position_locator (
   input  logic                          clock,
   input  logic                          reset,
   dbpl_req_if.sink                      req_chan,
   dbpl_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dbpl_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dbpl_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dbpl_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import dbpl_pkg::*;

   logic             cfg_wr;
   logic [LEN_W-1:0] seq_len;
   dp_status_type    status;
   dp_op_type        op;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_SEQ_LENGTH);
   assign csr_prdata = (csr_paddr == CSR_SEQ_LENGTH) ? CSR_DW'(seq_len) : '0;

   dbpl_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .op        (op)
   );

   dbpl_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg_wr       (cfg_wr),
      .cfg_len      (csr_pwdata[LEN_W-1:0]),
      .seq_len      (seq_len),
      .op           (op),
      .in_bits      (req_chan.window_bits),
      .in_len       (req_chan.window_length),
      .in_valid     (req_chan.valid_count),
      .status       (status),
      .out_found    (rsp_chan.found),
      .out_location (rsp_chan.location),
      .out_order    (rsp_chan.order)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// de bruijn position locator testbench
// Drives window requests through the valid/ready channel, reprograms the
// sequence length over the register port between phases, and checks each
// response against a local model of the label sequence and its search.
// ----------------------------------------------------------------------------

class locate_board;
   typedef struct packed {
      logic                          found;
      logic [dbpl_pkg::LOC_W-1:0]    location;
      logic [dbpl_pkg::ORDER_W-1:0]  order;
   } loc_rsp_type;

   int unsigned seq_len;
   int unsigned order_k;
   bit          built;
   bit          labels[dbpl_pkg::MAX_LEN];
   loc_rsp_type pending[$];
   int          mismatches;
   int          responses;

   function new();
      seq_len    = 1024;
      order_k    = calc_order(seq_len);
      built      = 0;
      mismatches = 0;
      responses  = 0;
   endfunction

   function int unsigned calc_order(int unsigned n);
      int unsigned k;
      k = 1;
      while (k < dbpl_pkg::MAX_ORDER && int'(n) - int'(k) + 1 > (1 << k)) k++;
      return k;
   endfunction

   function void set_length(int unsigned value);
      int unsigned v;
      v = value & 32'h7ff;
      if (v < 2) v = 2;
      if (v > dbpl_pkg::MAX_LEN) v = dbpl_pkg::MAX_LEN;
      seq_len = v;
      order_k = calc_order(v);
      built   = 0;
   endfunction

   function void build_sequence();
      bit          seen0[dbpl_pkg::NODES];
      bit          seen1[dbpl_pkg::NODES];
      int unsigned stk[dbpl_pkg::EDGE_SLOTS];
      bit          circ[dbpl_pkg::EDGE_SLOTS];
      int unsigned sp, cnt, edge_v, node, mask, j;
      mask = (1 << (order_k - 1)) - 1;
      foreach (seen0[i]) begin
         seen0[i] = 0;
         seen1[i] = 0;
      end
      sp = 0;
      cnt = 0;
      stk[sp++] = 0;
      while (sp > 0) begin
         edge_v = stk[sp-1];
         node = edge_v & mask;
         if (!seen0[node] && sp < dbpl_pkg::EDGE_SLOTS) begin
            seen0[node] = 1;
            stk[sp++] = node << 1;
         end else if (!seen1[node] && sp < dbpl_pkg::EDGE_SLOTS) begin
            seen1[node] = 1;
            stk[sp++] = (node << 1) | 1;
         end else begin
            if (cnt < dbpl_pkg::EDGE_SLOTS) circ[cnt++] = edge_v[0];
            sp--;
         end
      end
      for (int unsigned i = 0; i < seq_len; i++) begin
         labels[i] = 0;
         if (i + 1 >= order_k) begin
            j = i + 2 - order_k;
            if (j < cnt) labels[i] = circ[cnt-1-j];
         end
      end
      built = 1;
   endfunction

   function void note_request(logic [9:0] bits, logic [3:0] wlen, logic [3:0] vcnt);
      loc_rsp_type r;
      int          p;
      int unsigned tgt, curr, kmask;
      r.found = 0;
      r.location = '0;
      r.order = order_k[3:0];
      if (wlen >= 1 && wlen <= dbpl_pkg::MAX_ORDER) begin
         if (vcnt < wlen) begin
            p = int'(seq_len) - int'(wlen - vcnt) - 1;
            if (p >= 0) begin
               r.found = 1;
               r.location = p[9:0];
            end
         end else begin
            kmask = (1 << order_k) - 1;
            tgt = bits & ((1 << wlen) - 1);
            curr = 0;
            if (!built) build_sequence();
            for (int unsigned i = 0; i < order_k; i++) curr = (curr << 1) | labels[i];
            for (int unsigned i = 0; i + order_k <= seq_len; i++) begin
               if (curr == tgt) begin
                  r.found = 1;
                  r.location = i[9:0];
                  break;
               end
               if (i + order_k < seq_len) curr = ((curr << 1) | labels[i+order_k]) & kmask;
            end
         end
      end
      pending = {pending, r};
   endfunction

   function void check_response(logic found, logic [9:0] location, logic [3:0] order);
      loc_rsp_type e;
      responses++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response found=%0d loc=%0d order=%0d",
                                        found, location, order);
         return;
      end
      e = pending.pop_front();
      if (found !== e.found || location !== e.location || order !== e.order) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected found=%0d loc=%0d order=%0d, got %0d %0d %0d",
                     e.found, e.location, e.order, found, location, order);
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   bit          rsp_stall_off = 0;
   int          idle_cycles = 0;
   int          requests = 0;
   int          lengths_used = 0;

   dbpl_req_if req_chan();
   dbpl_rsp_if rsp_chan();

   locate_board board = new();

   de_bruijn_position_locator u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= rsp_stall_off || ($urandom_range(99) >= 33);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_response(rsp_chan.found, rsp_chan.location, rsp_chan.order);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 200000) begin
         $display("watchdog expired");
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(int unsigned value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= dbpl_pkg::CSR_SEQ_LENGTH;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      board.set_length(value);
      lengths_used++;
   endtask

   task automatic send_request(logic [9:0] bits, logic [3:0] wlen, logic [3:0] vcnt,
                               bit gaps);
      if (gaps) begin
         while ($urandom_range(99) < 33) begin
            req_chan.valid <= 0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1;
      req_chan.window_bits <= bits;
      req_chan.window_length <= wlen;
      req_chan.valid_count <= vcnt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_request(bits, wlen, vcnt);
      requests++;
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(int count, bit gaps);
      int unsigned k;
      logic [9:0]  bits;
      logic [3:0]  wlen, vcnt;
      for (int i = 0; i < count; i++) begin
         k = board.order_k;
         bits = 10'($urandom());
         if ($urandom_range(99) < 75) begin
            wlen = 4'(k);
            vcnt = $urandom_range(99) < 80 ? 4'(k) : 4'($urandom_range(15));
         end else begin
            wlen = 4'($urandom_range(15));
            vcnt = 4'($urandom_range(15));
         end
         send_request(bits, wlen, vcnt, gaps);
      end
   endtask

   initial begin
      int unsigned lens[10];
      lens = '{2, 3, 5, 17, 40, 100, 1024, 0, 2047, 1500};
      req_chan.valid = 0;
      req_chan.window_bits = '0;
      req_chan.window_length = '0;
      req_chan.valid_count = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed at reset length
      send_request(10'h3ff, 4'd10, 4'd10, 1);
      send_request(10'h000, 4'd10, 4'd10, 1);
      send_request(10'h155, 4'd10, 4'd15, 1);
      send_request(10'h2aa, 4'd0, 4'd0, 1);
      send_request(10'h001, 4'd11, 4'd11, 1);
      send_request(10'h001, 4'd15, 4'd3, 1);
      send_request(10'h0ff, 4'd10, 4'd0, 1);
      send_request(10'h0ff, 4'd1, 4'd0, 1);
      send_request(10'h001, 4'd1, 4'd1, 1);
      send_request(10'h005, 4'd3, 4'd9, 1);
      drain();
      csr_write(2);
      send_request(10'h000, 4'd1, 4'd1, 1);
      send_request(10'h001, 4'd1, 4'd1, 1);
      send_request(10'h002, 4'd2, 4'd2, 1);
      send_request(10'h000, 4'd4, 4'd1, 1);
      send_request(10'h000, 4'd2, 4'd0, 1);
      drain();
      csr_write(1024);
      random_phase(20, 0);
      drain();
      foreach (lens[i]) begin
         csr_write(lens[i]);
         rsp_stall_off = (i == 3);
         random_phase(lens[i] > 200 || lens[i] == 0 ? 15 : 65, i != 3);
         drain();
      end
      rsp_stall_off = 0;
      drain();
      $display("covered %0d requests over %0d length settings, %0d responses checked",
               requests, lengths_used, board.responses);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d responses missing", board.mismatches,
                  board.pending.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
